// ----- sv/ise_pkg.sv -----
// Shared types and constants for the insertion sort engine.
package ise_pkg;

	localparam int MAX_N_DEF = 64;
	localparam int VALUE_W   = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_INS,
		ST_CMP,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_in;   // capture item, pointer <= count
		logic mark_ovf;  // note a dropped element
		logic wr_new;    // store new value at pointer, count++
		logic rd_prev;   // read entry below pointer
		logic shift;     // move read entry up to pointer, pointer--
		logic out_start; // pointer <= 0
		logic rd_cur;    // read entry at pointer
		logic out_load;  // fill output register, pointer++
		logic clear;     // empty the store for the next list
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic full;      // store holds MAX_N elements
		logic ptr_zero;  // insertion reached the bottom
		logic less;      // new value < entry read
		logic last;      // captured item closes the list
		logic at_end;    // pointer is on the final element
		logic out_free;  // output register can take a value
	} sts_t;

endpackage

// ----- sv/insertion_sort_engine.sv -----
// Insertion sort engine: stable ascending sort of signed 32-bit lists.
// Input: the idle state takes an item, then in_stall holds while it is checked and
// walked past each held element greater than it, a read then a compare per entry.
// A full store drops the item in the check state. Output: after the last insertion,
// each result is read, then loaded while out_stall does not hold the previous one.
// Reset clears controller, element count and overflow flag; the store is left as is.
module insertion_sort_engine #(
	parameter int MAX_N = ise_pkg::MAX_N_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ise_pkg::VALUE_W-1:0] value,
	input  logic                        is_last,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ise_pkg::VALUE_W-1:0] sorted_value,
	output logic                        end_of_list,
	output logic                        overflowed
);

	ise_pkg::cmd_t cmd;
	ise_pkg::sts_t sts;

	// Controller: sequences the insertion walk down the store (a read and a
	// compare per entry) and the read-out towards the output register.
	ise_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// Datapath: the sorted store as a one-write, one-read memory, the walk
	// pointer, element count, overflow flag and the output register, which
	// lets the controller return to idle while the last result waits.
	ise_datapath #(
		.MAX_N (MAX_N)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.value        (value),
		.is_last      (is_last),
		.sorted_value (sorted_value),
		.end_of_list  (end_of_list),
		.overflowed   (overflowed),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

	// An accepted item always keeps the block busy for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after an accepted item");

	// A stalled result keeps its value and marks.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sorted_value)
		&& $stable(end_of_list) && $stable(overflowed))
		else $error("stalled result changed");

	// The overflow flag is constant across the results of one list.
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !end_of_list |=>
		!out_valid || (overflowed == $past(overflowed)))
		else $error("overflow flag changed within a list");

endmodule

// ----- sv/ise_ctrl.sv -----
// Controller state machine for the insertion sort engine.
module ise_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  ise_pkg::sts_t sts,
	output ise_pkg::cmd_t cmd,
	output logic          in_stall
);

	ise_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ise_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ise_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ise_pkg::ST_CHECK;
				end
			end
			ise_pkg::ST_CHECK: begin
				if (sts.full) begin
					cmd.mark_ovf = 1'b1;
					if (sts.last) begin
						cmd.out_start = 1'b1;
						state_d       = ise_pkg::ST_OUT_RD;
					end else begin
						state_d = ise_pkg::ST_IDLE;
					end
				end else begin
					state_d = ise_pkg::ST_INS;
				end
			end
			ise_pkg::ST_INS: begin
				if (sts.ptr_zero) begin
					cmd.wr_new = 1'b1;
					if (sts.last) begin
						cmd.out_start = 1'b1;
						state_d       = ise_pkg::ST_OUT_RD;
					end else begin
						state_d = ise_pkg::ST_IDLE;
					end
				end else begin
					cmd.rd_prev = 1'b1;
					state_d     = ise_pkg::ST_CMP;
				end
			end
			ise_pkg::ST_CMP: begin
				if (sts.less) begin
					cmd.shift = 1'b1;
					state_d   = ise_pkg::ST_INS;
				end else begin
					cmd.wr_new = 1'b1;
					if (sts.last) begin
						cmd.out_start = 1'b1;
						state_d       = ise_pkg::ST_OUT_RD;
					end else begin
						state_d = ise_pkg::ST_IDLE;
					end
				end
			end
			ise_pkg::ST_OUT_RD: begin
				cmd.rd_cur = 1'b1;
				state_d    = ise_pkg::ST_OUT_LD;
			end
			ise_pkg::ST_OUT_LD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.at_end) begin
						cmd.clear = 1'b1;
						state_d   = ise_pkg::ST_IDLE;
					end else begin
						state_d = ise_pkg::ST_OUT_RD;
					end
				end
			end
			default: begin
				state_d = ise_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/ise_datapath.sv -----
// Datapath of the insertion sort engine: store, pointer, count, output register.
module ise_datapath #(
	parameter int MAX_N = ise_pkg::MAX_N_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ise_pkg::cmd_t               cmd,
	output ise_pkg::sts_t               sts,
	input  logic [ise_pkg::VALUE_W-1:0] value,
	input  logic                        is_last,
	output logic [ise_pkg::VALUE_W-1:0] sorted_value,
	output logic                        end_of_list,
	output logic                        overflowed,
	output logic                        out_valid,
	input  logic                        out_stall
);

	localparam int AW = $clog2(MAX_N);
	localparam int CW = $clog2(MAX_N + 1);

	logic [ise_pkg::VALUE_W-1:0] mem [MAX_N];
	logic [ise_pkg::VALUE_W-1:0] val_q;
	logic [ise_pkg::VALUE_W-1:0] rd_q;
	logic                        last_q;
	logic [CW-1:0]               cnt_q;
	logic [CW-1:0]               ptr_q;
	logic                        ovf_q;
	logic [CW-1:0]               ptr_dec;
	logic [CW-1:0]               ptr_inc;
	logic                        we;
	logic [ise_pkg::VALUE_W-1:0] wdata;
	logic                        re;
	logic [AW-1:0]               raddr;

	assign ptr_dec = ptr_q - CW'(1);
	assign ptr_inc = ptr_q + CW'(1);

	// single write port, single registered read port
	assign we    = cmd.wr_new | cmd.shift;
	assign wdata = cmd.shift ? rd_q : val_q;
	assign re    = cmd.rd_prev | cmd.rd_cur;
	assign raddr = cmd.rd_prev ? ptr_dec[AW-1:0] : ptr_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[ptr_q[AW-1:0]] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			val_q  <= value;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				ptr_q <= cnt_q;
			end else if (cmd.out_start) begin
				ptr_q <= '0;
			end else if (cmd.shift) begin
				ptr_q <= ptr_dec;
			end else if (cmd.out_load) begin
				ptr_q <= ptr_inc;
			end
			if (cmd.clear) begin
				cnt_q <= '0;
			end else if (cmd.wr_new) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.clear) begin
				ovf_q <= 1'b0;
			end else if (cmd.mark_ovf) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sorted_value <= rd_q;
			end_of_list  <= (ptr_inc == cnt_q);
			overflowed   <= ovf_q;
		end
	end

	assign sts.full     = (cnt_q == CW'(MAX_N));
	assign sts.ptr_zero = (ptr_q == '0);
	assign sts.less     = ($signed(val_q) < $signed(rd_q));
	assign sts.last     = last_q;
	assign sts.at_end   = (ptr_inc == cnt_q);
	assign sts.out_free = !out_valid || !out_stall;

endmodule

// ----- sim/testbench.sv -----
// Self-checking bench for the insertion sort engine: random lists against a sorting predictor.
module testbench;

	typedef struct {
		logic [ise_pkg::VALUE_W-1:0] value;
		logic                        is_last;
		bit                          drain;   // hold this item back until all results are in
	} list_item_t;

	typedef struct {
		logic signed [ise_pkg::VALUE_W-1:0] value;
		logic                               end_of_list;
		logic                               overflowed;
	} sorted_result_t;

	localparam int CAPACITY      = ise_pkg::MAX_N_DEF;
	// Longest insertion walks the whole store; leave plenty on top.
	localparam int SETTLE_CYCLES = 4 * CAPACITY + 100;
	localparam int RANDOM_ITEMS  = 480;

	logic                               clk       = 1'b0;
	logic                               arst_n    = 1'b0;
	logic                               in_valid  = 1'b0;
	logic [ise_pkg::VALUE_W-1:0]        value     = '0;
	logic                               is_last   = 1'b0;
	logic                               out_stall = 1'b0;
	logic                               in_stall;
	logic                               out_valid;
	logic [ise_pkg::VALUE_W-1:0]        sorted_value;
	logic                               end_of_list;
	logic                               overflowed;

	// Sorting predictor state
	logic signed [ise_pkg::VALUE_W-1:0] held_values[$];
	bit                                 dropped_any = 1'b0;

	list_item_t                         unsorted_items[$];
	sorted_result_t                     sorted_due[$];
	int unsigned                        fail_count = 0;

	always #10 clk = ~clk;

	insertion_sort_engine u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.end_of_list  (end_of_list),
		.overflowed   (overflowed)
	);

	// Stable insert: new value goes after every held value <= it.
	// A last item releases the whole list with end and overflow marks.
	function void insert_element(list_item_t it);
		int                                 j;
		logic signed [ise_pkg::VALUE_W-1:0] v;
		sorted_result_t                     r;
		v = $signed(it.value);
		if (held_values.size() >= CAPACITY) begin
			dropped_any = 1'b1;
		end else begin
			j = held_values.size();
			while (j > 0 && v < held_values[j-1])
				j--;
			held_values.insert(j, v);
		end
		if (it.is_last) begin
			foreach (held_values[k]) begin
				r.value       = held_values[k];
				r.end_of_list = (k == held_values.size() - 1);
				r.overflowed  = dropped_any;
				sorted_due.push_back(r);
			end
			held_values.delete();
			dropped_any = 1'b0;
		end
	endfunction

	// Idle cycles before the next item; occasional bursts with none at all.
	function automatic int unsigned draw_wait(inout int unsigned burst);
		if (burst != 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	function automatic logic [ise_pkg::VALUE_W-1:0] rand_element();
		case ($urandom_range(0, 5))
			0, 1, 5: return $urandom;
			2:       return ise_pkg::VALUE_W'($signed($urandom_range(0, 8)) - 4);   // heavy duplicates
			3: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return ($urandom_range(0, 1) ? 32'hFFFF_FF00 : 32'h0)
				| ise_pkg::VALUE_W'($urandom_range(0, 255));
		endcase
	endfunction

	function void push_item(logic [ise_pkg::VALUE_W-1:0] v, logic last);
		list_item_t it;
		it.value   = v;
		it.is_last = last;
		it.drain   = 1'b0;
		unsorted_items.push_back(it);
	endfunction

	function void push_random_list(int unsigned len, bit drain);
		list_item_t it;
		for (int unsigned i = 0; i < len; i++) begin
			it.value   = rand_element();
			it.is_last = (i == len - 1);
			it.drain   = drain && (i == 0);
			unsorted_items.push_back(it);
		end
	endfunction

	// Item driver: payload held while stalled, predictor fed on acceptance.
	int unsigned send_gap   = 0;
	int unsigned send_burst = 0;
	list_item_t  on_wire;

	always @(posedge clk or negedge arst_n) begin : drive_items
		if (!arst_n) begin
			in_valid <= 1'b0;
			value    <= '0;
			is_last  <= 1'b0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid)
				insert_element(on_wire);
			if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (unsorted_items.size() != 0 &&
					(!unsorted_items[0].drain || sorted_due.size() == 0)) begin
				on_wire  = unsorted_items.pop_front();
				in_valid <= 1'b1;
				value    <= on_wire.value;
				is_last  <= on_wire.is_last;
				send_gap = draw_wait(send_burst);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor: compares each accepted result with the oldest expectation.
	int unsigned recv_hold  = 0;
	int unsigned recv_burst = 0;

	always @(posedge clk or negedge arst_n) begin : check_results
		sorted_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (sorted_due.size() == 0) begin
					$error("unexpected result: sorted_value %0d", $signed(sorted_value));
					fail_count++;
				end else begin
					want = sorted_due.pop_front();
					if (sorted_value !== want.value) begin
						$error("sorted_value: expected %0d, got %0d",
							want.value, $signed(sorted_value));
						fail_count++;
					end
					if (end_of_list !== want.end_of_list) begin
						$error("end_of_list: expected %0b, got %0b",
							want.end_of_list, end_of_list);
						fail_count++;
					end
					if (overflowed !== want.overflowed) begin
						$error("overflowed: expected %0b, got %0b",
							want.overflowed, overflowed);
						fail_count++;
					end
				end
				recv_hold = draw_wait(recv_burst);
			end
			if (recv_hold != 0) begin
				recv_hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		int unsigned random_count;
		int unsigned len;
		bit          drain;

		// lone extremes
		push_item(32'h8000_0000, 1'b1);
		push_item(32'h7FFF_FFFF, 1'b1);
		// extremes, zero, -1 and duplicates mixed
		push_item(32'h7FFF_FFFF, 1'b0);
		push_item(32'h0000_0000, 1'b0);
		push_item(32'h8000_0000, 1'b0);
		push_item(32'hFFFF_FFFF, 1'b0);
		push_item(32'h0000_0001, 1'b0);
		push_item(32'h8000_0000, 1'b0);
		push_item(32'h7FFF_FFFF, 1'b1);
		// already ascending
		push_item(32'hFFFF_FFFD, 1'b0);
		push_item(32'hFFFF_FFFF, 1'b0);
		push_item(32'h0000_0002, 1'b0);
		push_item(32'h0000_0005, 1'b1);
		// descending, each insert walks to the bottom
		push_item(32'h0000_0005, 1'b0);
		push_item(32'h0000_0002, 1'b0);
		push_item(32'hFFFF_FFFF, 1'b0);
		push_item(32'hFFFF_FFFD, 1'b1);
		// all equal
		push_item(32'h5555_5555, 1'b0);
		push_item(32'h5555_5555, 1'b0);
		push_item(32'h5555_5555, 1'b1);
		// alternating bit patterns
		push_item(32'hAAAA_AAAA, 1'b0);
		push_item(32'h5555_5555, 1'b1);

		// exactly full, last dropped on a full store, several dropped
		push_random_list(CAPACITY, 1'b1);
		push_random_list(CAPACITY + 1, 1'b1);
		push_random_list(CAPACITY + 5, 1'b0);
		random_count = 3 * CAPACITY + 6 + 22;
		while (random_count < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 11) == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 8)
				: $urandom_range(1, 12);
			drain = ($urandom_range(0, 9) == 0);
			push_random_list(len, drain);
			random_count += len;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// sample between edges so the driver's updates have settled
		while (unsorted_items.size() != 0 || in_valid || sorted_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0 && sorted_due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/ise_pkg.sv
sv/ise_ctrl.sv
sv/ise_datapath.sv
sv/insertion_sort_engine.sv
sim/testbench.sv
